[design/ppp_pkg.sv]
// ----------------------------------------------------------------------------
// ppp_pkg
// shared constants, types and helpers of the perspective point projector
// ----------------------------------------------------------------------------
package ppp_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int MATRIX_WORDS  = 16;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 14;

    localparam logic [CFG_IDX_W-1:0]  CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0]  CFG_SCREEN_HEIGHT = 1'b1;
    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET       = 14'd1920;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET      = 14'd1080;

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_PROJECT = 1'b1;

    typedef struct packed {
        logic valid;
        logic visible;
    } t_ctl;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[design/perspective_point_projector.sv]
// ----------------------------------------------------------------------------
// perspective_point_projector
// projects world points through a 4x4 view matrix to screen pixels
// ----------------------------------------------------------------------------
// One request is taken per clock while o_stall is low. A project request
// passes through the clip stages, the 34-stage divider for the two divisions
// by clip w and the final screen stages; load requests write the matrix on
// acceptance and give no result. The whole pipeline advances together and
// holds only while a result waits in the output register under stall.
module perspective_point_projector
    import ppp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ppp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ppp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_mode,
    input  logic [3:0]                     i_coeff_index,
    input  logic signed [31:0]             i_coeff_value,
    input  logic signed [31:0]             i_point_x,
    input  logic signed [31:0]             i_point_y,
    input  logic signed [31:0]             i_point_z,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_visible,
    output logic signed [31:0]             o_screen_x,
    output logic signed [31:0]             o_screen_y
);

    localparam int DLAT = 34;

    logic                en;
    t_ctl                clip_ctl;
    logic                neg_x, neg_y, ovf_x, ovf_y, dneg_x, dneg_y;
    logic [31:0]         mag_x, mag_y;
    logic [30:0]         clip_w;
    logic [32:0]         q_x, q_y;

    logic [CFG_DATA_W-1:0] r_width, r_height;
    t_ctl                r_dctl [DLAT];
    t_ctl                r_e_ctl, r_f_ctl;
    logic signed [33:0]  r_e_sx, r_e_sy;
    logic signed [48:0]  r_f_px, r_f_py;
    logic                r_out_valid, r_out_vis;
    logic signed [31:0]  r_out_x, r_out_y;

    logic signed [31:0]  n_nx, n_ny;
    logic signed [48:0]  n_hx, n_hy;

    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ppp_clip #(.FRAC_BITS(FRAC_BITS)) u_clip (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (i_valid),
        .i_mode        (i_mode),
        .i_coeff_index (i_coeff_index),
        .i_coeff_value (i_coeff_value),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_point_z     (i_point_z),
        .o_ctl         (clip_ctl),
        .o_neg_x       (neg_x),
        .o_neg_y       (neg_y),
        .o_mag_x       (mag_x),
        .o_mag_y       (mag_y),
        .o_w           (clip_w)
    );

    ppp_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_neg (neg_x),
        .i_mag (mag_x),
        .i_w   (clip_w),
        .o_neg (dneg_x),
        .o_ovf (ovf_x),
        .o_q   (q_x)
    );

    ppp_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_neg (neg_y),
        .i_mag (mag_y),
        .i_w   (clip_w),
        .o_neg (dneg_y),
        .o_ovf (ovf_y),
        .o_q   (q_y)
    );

    function automatic logic signed [31:0] ndc(input logic neg, input logic ovf,
                                               input logic [32:0] q);
        logic signed [31:0] r;
        if (neg) begin
            r = (ovf || q > 33'h080000000) ? 32'sh80000000 : 32'(~q + 33'd1);
        end else begin
            r = (ovf || q > 33'h07fffffff) ? 32'sh7fffffff : 32'(q);
        end
        return r;
    endfunction

    always_comb begin
        n_nx = ndc(dneg_x, ovf_x, q_x);
        n_ny = ndc(dneg_y, ovf_y, q_y);
        n_hx = r_f_px[48] ? (r_f_px + 49'sd1) >>> 1 : r_f_px >>> 1;
        n_hy = r_f_py[48] ? (r_f_py + 49'sd1) >>> 1 : r_f_py >>> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DLAT; k++) begin
                r_dctl[k] <= '0;
            end
            r_e_ctl     <= '0;
            r_f_ctl     <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_dctl[0] <= clip_ctl;
            for (int k = 1; k < DLAT; k++) begin
                r_dctl[k] <= r_dctl[k-1];
            end
            r_e_ctl     <= r_dctl[DLAT-1];
            r_f_ctl     <= r_e_ctl;
            r_out_valid <= r_f_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_sx    <= (34'sd1 <<< FRAC_BITS) + 34'(n_nx);
            r_e_sy    <= (34'sd1 <<< FRAC_BITS) - 34'(n_ny);
            r_f_px    <= $signed({35'd0, r_width}) * 49'(r_e_sx);
            r_f_py    <= $signed({35'd0, r_height}) * 49'(r_e_sy);
            r_out_vis <= r_f_ctl.visible;
            r_out_x   <= r_f_ctl.visible ? sat32(64'(n_hx)) : '0;
            r_out_y   <= r_f_ctl.visible ? sat32(64'(n_hy)) : '0;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_visible  = r_out_vis;
    assign o_screen_x = r_out_x;
    assign o_screen_y = r_out_y;

    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_visible |-> o_screen_x == 0 && o_screen_y == 0)
        else $error("hidden point with nonzero screen position");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_stall |=> r_out_valid && $stable(r_out_x) && $stable(r_out_y))
        else $error("pending result lost under stall");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a waiting result");

endmodule

[design/ppp_clip.sv]
// ----------------------------------------------------------------------------
// ppp_clip
// matrix store, clip products and sums, visibility and divider setup
// ----------------------------------------------------------------------------
module ppp_clip #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic               i_mode,
    input  logic [3:0]         i_coeff_index,
    input  logic signed [31:0] i_coeff_value,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    output ppp_pkg::t_ctl      o_ctl,
    output logic               o_neg_x,
    output logic               o_neg_y,
    output logic [31:0]        o_mag_x,
    output logic [31:0]        o_mag_y,
    output logic [30:0]        o_w
);
    import ppp_pkg::*;

    localparam int PW  = 64 - FRAC_BITS;
    localparam int SW  = 66 - FRAC_BITS;
    localparam int THR = ((1 << FRAC_BITS) + 50) / 100;

    logic signed [31:0] r_mat [MATRIX_WORDS];
    logic               r_a_valid, r_b_valid, r_c_valid;
    t_ctl               r_d_ctl;
    logic signed [31:0] r_a_pt [3];
    logic signed [31:0] r_a_c  [3][4];
    logic signed [PW-1:0] r_b_p [3][3];
    logic signed [31:0] r_b_k  [3];
    logic signed [SW-1:0] r_c_sum [3];
    logic               r_d_neg_x, r_d_neg_y;
    logic [31:0]        r_d_mag_x, r_d_mag_y;
    logic [30:0]        r_d_w;

    logic signed [31:0] n_cx, n_cy, n_cw;
    logic               n_vis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MATRIX_WORDS; k++) begin
                r_mat[k] <= '0;
            end
        end else if (i_en && i_valid && i_mode == MODE_LOAD) begin
            r_mat[i_coeff_index] <= i_coeff_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_ctl   <= '0;
        end else if (i_en) begin
            r_a_valid <= i_valid && i_mode == MODE_PROJECT;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_ctl   <= '{valid: r_c_valid, visible: n_vis};
        end
    end

    always_comb begin
        n_cx  = sat32(64'(r_c_sum[0]));
        n_cy  = sat32(64'(r_c_sum[1]));
        n_cw  = sat32(64'(r_c_sum[2]));
        n_vis = r_c_sum[2] >= $signed(SW'(THR));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_pt[0] <= i_point_x;
            r_a_pt[1] <= i_point_y;
            r_a_pt[2] <= i_point_z;
            for (int j = 0; j < 3; j++) begin
                for (int c = 0; c < 4; c++) begin
                    r_a_c[j][c] <= r_mat[4'(((j == 2) ? 3 : j) * 4 + c)];
                end
            end
            for (int j = 0; j < 3; j++) begin
                for (int c = 0; c < 3; c++) begin
                    r_b_p[j][c] <= PW'((64'(r_a_pt[c]) * 64'(r_a_c[j][c])) >>> FRAC_BITS);
                end
                r_b_k[j] <= r_a_c[j][3];
            end
            for (int j = 0; j < 3; j++) begin
                r_c_sum[j] <= SW'(r_b_p[j][0]) + SW'(r_b_p[j][1])
                            + SW'(r_b_p[j][2]) + SW'(r_b_k[j]);
            end
            r_d_neg_x <= n_cx[31];
            r_d_neg_y <= n_cy[31];
            r_d_mag_x <= n_cx[31] ? (~n_cx) + 32'd1 : n_cx;
            r_d_mag_y <= n_cy[31] ? (~n_cy) + 32'd1 : n_cy;
            r_d_w     <= n_cw[30:0];
        end
    end

    assign o_ctl   = r_d_ctl;
    assign o_neg_x = r_d_neg_x;
    assign o_neg_y = r_d_neg_y;
    assign o_mag_x = r_d_mag_x;
    assign o_mag_y = r_d_mag_y;
    assign o_w     = r_d_w;

endmodule

[design/ppp_div.sv]
// ----------------------------------------------------------------------------
// ppp_div
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// ----------------------------------------------------------------------------
module ppp_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic        i_neg,
    input  logic [31:0] i_mag,
    input  logic [30:0] i_w,
    output logic        o_neg,
    output logic        o_ovf,
    output logic [32:0] o_q
);
    import ppp_pkg::*;

    localparam int DW    = 32 + FRAC_BITS;
    localparam int STEPS = 33;

    logic [DW-1:0] n_dvd;
    logic [31:0]   n_hi;

    logic          r_neg [STEPS+1];
    logic          r_ovf [STEPS+1];
    logic [30:0]   r_w   [STEPS+1];
    logic [32:0]   r_d   [STEPS+1];
    logic [31:0]   r_rem [STEPS+1];
    logic [32:0]   r_q   [STEPS+1];

    always_comb begin
        n_dvd = {i_mag, {FRAC_BITS{1'b0}}};
        n_hi  = 32'(n_dvd >> 33);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg[0] <= i_neg;
            r_ovf[0] <= n_hi >= {1'b0, i_w};
            r_w[0]   <= i_w;
            r_d[0]   <= n_dvd[32:0];
            r_rem[0] <= n_hi;
            r_q[0]   <= '0;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [31:0] n_t;
        logic        n_ge;
        always_comb begin
            n_t  = {r_rem[k][30:0], r_d[k][STEPS-1-k]};
            n_ge = n_t >= {1'b0, r_w[k]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[k+1] <= r_neg[k];
                r_ovf[k+1] <= r_ovf[k];
                r_w[k+1]   <= r_w[k];
                r_d[k+1]   <= r_d[k];
                r_rem[k+1] <= n_ge ? n_t - {1'b0, r_w[k]} : n_t;
                r_q[k+1]   <= {r_q[k][31:0], n_ge};
            end
        end
    end

    assign o_neg = r_neg[STEPS];
    assign o_ovf = r_ovf[STEPS];
    assign o_q   = r_q[STEPS];

endmodule

[test/perspective_point_projector_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// perspective_point_projector_tb
// directed table plus random coefficient loads and point projections, every
// result checked in order against its table pixel or a fixed-point projection predictor
// ----------------------------------------------------------------------------
module perspective_point_projector_tb;
    import ppp_pkg::*;

    localparam int FB         = 16;
    localparam int LATENCY    = 40;
    localparam int WDOG_LIMIT = 20000;
    localparam int N_RANDOM   = 1300;

    typedef struct packed {
        logic        visible;
        logic [31:0] sx;
        logic [31:0] sy;
    } t_pix;

    typedef struct {
        logic        mode;
        logic [3:0]  idx;
        logic [31:0] cval;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic        typed;
        t_pix        pix;
    } t_row;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic mode = 1'b0;
    logic [3:0] coeff_index = '0;
    logic signed [31:0] coeff_value = '0;
    logic signed [31:0] point_x = '0;
    logic signed [31:0] point_y = '0;
    logic signed [31:0] point_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic visible;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;

    logic signed [31:0] view_matrix [MATRIX_WORDS];
    logic [13:0] scr_w;
    logic [13:0] scr_h;
    t_pix pixel_queue [$];
    int errors = 0;
    int idle_cycles = 0;
    bit stall_on = 1'b1;
    t_row dir_rows [$];

    always #1 clk = ~clk;

    perspective_point_projector dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data), .i_valid(in_valid), .o_stall(in_stall), .i_mode(mode),
        .i_coeff_index(coeff_index), .i_coeff_value(coeff_value), .i_point_x(point_x),
        .i_point_y(point_y), .i_point_z(point_z), .o_valid(out_valid),
        .i_stall(out_stall), .o_visible(visible), .o_screen_x(screen_x),
        .o_screen_y(screen_y)
    );

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint row_dot(int r, longint x, longint y, longint z);
        longint a, b, c;
        a = (x * longint'(view_matrix[r*4]))   >>> FB;
        b = (y * longint'(view_matrix[r*4+1])) >>> FB;
        c = (z * longint'(view_matrix[r*4+2])) >>> FB;
        return a + b + c + longint'(view_matrix[r*4+3]);
    endfunction

    function automatic t_pix project_point(logic signed [31:0] x, logic signed [31:0] y,
                                           logic signed [31:0] z);
        t_pix p;
        longint cw, cx, cy, nx, ny;
        p = '0;
        cw = row_dot(3, x, y, z);
        if (cw < ((longint'(1) << FB) + 50) / 100 || cw <= 0) return p;
        cx = clamp32(row_dot(0, x, y, z));
        cy = clamp32(row_dot(1, x, y, z));
        cw = clamp32(cw);
        nx = clamp32((cx <<< FB) / cw);
        ny = clamp32((cy <<< FB) / cw);
        p.visible = 1'b1;
        p.sx = clamp32((longint'(scr_w) * ((longint'(1) << FB) + nx)) / 2);
        p.sy = clamp32((longint'(scr_h) * ((longint'(1) << FB) - ny)) / 2);
        return p;
    endfunction

    task automatic gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return;
        in_valid <= 1'b0;
        repeat (r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 60)) @(negedge clk);
    endtask

    task automatic send(logic m, logic [3:0] idx, logic [31:0] cv, logic [31:0] x,
                        logic [31:0] y, logic [31:0] z, bit typed, t_pix tp);
        t_pix p;
        in_valid <= 1'b1;
        mode <= m; coeff_index <= idx; coeff_value <= cv;
        point_x <= x; point_y <= y; point_z <= z;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (m == MODE_LOAD) begin
            view_matrix[idx] = cv;
        end else begin
            p = project_point(x, y, z);
            if (typed && p !== tp)
                $display("%0t directed row disagrees with predictor: %h vs %h", $time, tp, p);
            pixel_queue.push_back(typed ? tp : p);
        end
        @(negedge clk);
        if (stall_on) gap();
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pixel_queue.size() != 0) @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    task automatic set_screen(logic [13:0] w, logic [13:0] h);
        cfg_we <= 1'b1; cfg_index <= CFG_SCREEN_WIDTH; cfg_data <= w;
        @(negedge clk);
        cfg_index <= CFG_SCREEN_HEIGHT; cfg_data <= h;
        @(negedge clk);
        cfg_we <= 1'b0;
        scr_w = w; scr_h = h;
    endtask

    function automatic logic [31:0] rnd_fx();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h8000_0000 | ($urandom_range(0, 1) ? 32'h7fff_ffff : 32'h0);
            2: return $signed($urandom_range(0, 8 << FB)) - (4 << FB);
            default: return $signed($urandom_range(0, 2 << FB)) - (1 << FB);
        endcase
    endfunction

    function automatic t_row mk(logic m, logic [3:0] i, logic [31:0] cv, logic [31:0] x,
                                logic [31:0] y, logic [31:0] z, bit typed, t_pix tp);
        t_row r;
        r.mode = m; r.idx = i; r.cval = cv; r.px = x; r.py = y; r.pz = z;
        r.typed = typed; r.pix = tp;
        return r;
    endfunction

    always @(posedge clk) begin
        t_pix exp_pix;
        if (rst_n && out_valid && !out_stall) begin
            if (pixel_queue.size() == 0) begin
                $display("%0t unexpected result: %b %h %h", $time, visible, screen_x, screen_y);
                errors++;
            end else begin
                exp_pix = pixel_queue.pop_front();
                if (visible !== exp_pix.visible || screen_x !== exp_pix.sx ||
                    screen_y !== exp_pix.sy) begin
                    $display("%0t mismatch: expected %b %h %h actual %b %h %h", $time,
                             exp_pix.visible, exp_pix.sx, exp_pix.sy,
                             visible, screen_x, screen_y);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (!stall_on) out_stall <= 1'b0;
        else if (r < 70) out_stall <= 1'b0;
        else if (r < 97) out_stall <= 1'b1;
        else begin
            out_stall <= 1'b1;
            repeat ($urandom_range(10, 50)) @(negedge clk);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        t_pix zero_pix;
        t_pix center;
        logic [31:0] one;
        int n;
        zero_pix = '0;
        one = 32'h0001_0000;
        for (int i = 0; i < MATRIX_WORDS; i++) view_matrix[i] = '0;
        scr_w = WIDTH_RESET; scr_h = HEIGHT_RESET;
        center = '{1'b1, 32'd960 << FB, 32'd540 << FB};
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // matrix cleared after reset: w is zero
        dir_rows.push_back(mk(MODE_PROJECT, 0, 0, 32'h7fffffff, 32'h80000000, one, 1, zero_pix));
        dir_rows.push_back(mk(MODE_LOAD, 15, one, 0, 0, 0, 0, zero_pix));
        dir_rows.push_back(mk(MODE_PROJECT, 0, 0, 0, 0, 0, 1, center));
        dir_rows.push_back(mk(MODE_LOAD, 15, 32'd655, 0, 0, 0, 0, zero_pix));
        dir_rows.push_back(mk(MODE_PROJECT, 0, 0, 0, 0, 0, 0, zero_pix));
        dir_rows.push_back(mk(MODE_LOAD, 15, 32'd654, 0, 0, 0, 0, zero_pix));
        dir_rows.push_back(mk(MODE_PROJECT, 0, 0, 32'h7fffffff, 0, 0, 1, zero_pix));
        dir_rows.push_back(mk(MODE_LOAD, 15, 32'h80000000, 0, 0, 0, 0, zero_pix));
        dir_rows.push_back(mk(MODE_PROJECT, 0, 0, one, one, one, 1, zero_pix));
        dir_rows.push_back(mk(MODE_LOAD, 15, one, 0, 0, 0, 0, zero_pix));
        dir_rows.push_back(mk(MODE_LOAD, 0, one, 0, 0, 0, 0, zero_pix));
        dir_rows.push_back(mk(MODE_LOAD, 5, 32'h7fffffff, 0, 0, 0, 0, zero_pix));
        dir_rows.push_back(mk(MODE_LOAD, 3, 32'h80000000, 0, 0, 0, 0, zero_pix));
        dir_rows.push_back(mk(MODE_LOAD, 14, 32'h7fffffff, 0, 0, 0, 0, zero_pix));
        dir_rows.push_back(mk(MODE_PROJECT, 0, 0, one, 32'h7fffffff, 32'h80000000, 0, zero_pix));
        dir_rows.push_back(mk(MODE_PROJECT, 0, 0, 32'h80000000, 32'hffffffff, 32'h7fffffff,
                              0, zero_pix));
        dir_rows.push_back(mk(MODE_PROJECT, 0, 0, 32'h00008000, one, 0, 0, zero_pix));
        dir_rows.push_back(mk(MODE_LOAD, 14, 0, 0, 0, 0, 0, zero_pix));
        foreach (dir_rows[i])
            send(dir_rows[i].mode, dir_rows[i].idx, dir_rows[i].cval, dir_rows[i].px,
                 dir_rows[i].py, dir_rows[i].pz, dir_rows[i].typed, dir_rows[i].pix);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_screen(14'd1, 14'd8192);
                1: set_screen(14'h3fff, 14'd0);
                2: set_screen(14'd8192, 14'd1);
                default: set_screen(14'($urandom_range(1, 8192)), 14'($urandom_range(1, 8192)));
            endcase
            stall_on = (phase != 2);
            n = 0;
            while (n < N_RANDOM / 4) begin
                if ($urandom_range(0, 99) < 25) begin
                    // mostly a well-formed w row so points are visible
                    if ($urandom_range(0, 3) != 0 && $urandom_range(0, 1))
                        send(MODE_LOAD, 4'd12 + 4'($urandom_range(0, 2)),
                             $signed($urandom_range(0, 1 << FB)) - (1 << (FB - 1)),
                             0, 0, 0, 0, zero_pix);
                    else if ($urandom_range(0, 3) != 0)
                        send(MODE_LOAD, 4'd15, $urandom_range(1 << (FB - 2), 8 << FB),
                             0, 0, 0, 0, zero_pix);
                    else
                        send(MODE_LOAD, 4'($urandom_range(0, 15)), rnd_fx(), 0, 0, 0, 0,
                             zero_pix);
                end else begin
                    send(MODE_PROJECT, 4'($urandom_range(0, 15)), $urandom(),
                         rnd_fx(), rnd_fx(), rnd_fx(), 0, zero_pix);
                end
                n++;
                if (phase == 1 && n == 150) begin
                    // hold off until the pipeline is empty
                    in_valid <= 1'b0;
                    @(negedge clk);
                    while (pixel_queue.size() != 0) @(negedge clk);
                end
            end
            drain();
        end

        if (errors == 0 && pixel_queue.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
